// File: rtl/core/ardss_pkg.sv
// Shared types and constants for the allreduce schedule sequencer.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package ardss_pkg;

    localparam int MAX_RANKS = 1024;
    localparam int RANK_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MY_RANK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RANKS = 2'd1;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_RANKS);

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START_PRE  = 3'd1,
        PH_DONE_PRE   = 3'd2,
        PH_START_BF   = 3'd3,
        PH_DONE_BF    = 3'd4,
        PH_START_POST = 3'd5,
        PH_DONE_POST  = 3'd6,
        PH_RESULT     = 3'd7
    } t_phase;

    typedef struct packed {
        logic opcode;
        logic local_write_done;
        logic incoming_write_done;
        logic send_complete;
        logic recv_complete;
    } t_in_word;

    typedef struct packed {
        logic              issue_send;
        logic              issue_recv;
        logic [RANK_W-1:0] peer_rank;
        logic              recv_target;
        logic              do_reduce;
        logic              reduce_order;
        logic              finished;
        logic [2:0]        phase_now;
    } t_out_word;

    typedef struct packed {
        t_phase             phase;
        logic [COUNT_W-1:0] stage_mask;
        logic [RANK_W-1:0]  logical_rank;
        logic [RANK_W-1:0]  stage_partner;
        logic [COUNT_W-1:0] pow2_floor;
        logic [RANK_W-1:0]  remainder_count;
    } t_seq_state;

    typedef struct packed {
        t_phase             phase;
        logic [RANK_W-1:0]  logical_rank;
        logic [COUNT_W-1:0] pow2_floor;
        logic [RANK_W-1:0]  remainder_count;
    } t_start_info;

endpackage

// File: rtl/core/ardss_start.sv
// Start decode: clamps the rank count, finds its power-of-two floor, remainder,
// logical rank and first phase. Depends on ardss_pkg.
`timescale 1ns / 1ps

module ardss_start (
    input  logic [ardss_pkg::RANK_W-1:0]  i_my_rank,
    input  logic [ardss_pkg::COUNT_W-1:0] i_num_ranks,
    output ardss_pkg::t_start_info        o_info
);
    import ardss_pkg::*;

    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] pow2;
    logic [COUNT_W-1:0] rem_full;
    logic [RANK_W-1:0]  rem;
    logic [COUNT_W-1:0] rank_ext;

    always_comb begin
        if (i_num_ranks == '0) begin
            count = COUNT_W'(1);
        end else if (i_num_ranks > MAX_COUNT) begin
            count = MAX_COUNT;
        end else begin
            count = i_num_ranks;
        end
    end

    // leading-one detect
    always_comb begin
        pow2 = COUNT_W'(1);
        for (int i = 0; i < COUNT_W; i++) begin
            if (count[i]) begin
                pow2 = COUNT_W'(1) << i;
            end
        end
    end

    assign rem_full = count - pow2;
    assign rem      = rem_full[RANK_W-1:0];
    assign rank_ext = {1'b0, i_my_rank};

    always_comb begin
        o_info.pow2_floor      = pow2;
        o_info.remainder_count = rem;
        if (rank_ext >= count) begin
            o_info.logical_rank = '0;
            o_info.phase        = PH_RESULT;
        end else if (rank_ext < {rem, 1'b0}) begin
            o_info.logical_rank = i_my_rank[0] ? (i_my_rank >> 1) : '0;
            o_info.phase        = PH_START_PRE;
        end else begin
            o_info.logical_rank = i_my_rank - rem;
            o_info.phase        = PH_START_BF;
        end
    end

endmodule

// File: rtl/core/ardss_step.sv
// Per-item sequencing: next phase, stage mask and partner, and the command word.
// Depends on ardss_pkg; takes the start decode from ardss_start.
`timescale 1ns / 1ps

module ardss_step (
    input  ardss_pkg::t_in_word          i_word,
    input  ardss_pkg::t_seq_state        i_state,
    input  ardss_pkg::t_start_info       i_start,
    input  logic [ardss_pkg::RANK_W-1:0] i_my_rank,
    output ardss_pkg::t_seq_state        o_state,
    output ardss_pkg::t_out_word         o_word
);
    import ardss_pkg::*;

    logic               even;
    logic               in_pre;
    logic [COUNT_W-1:0] rank_ext;
    logic [COUNT_W-1:0] rem_ext;
    logic [COUNT_W-1:0] dst;
    logic [COUNT_W-1:0] partner;
    logic               mask_done;
    logic [RANK_W-1:0]  rank_up;
    logic [RANK_W-1:0]  rank_dn;

    assign even      = ~i_my_rank[0];
    assign rank_ext  = {1'b0, i_my_rank};
    assign rem_ext   = {1'b0, i_state.remainder_count};
    assign in_pre    = rank_ext < {i_state.remainder_count, 1'b0};
    assign dst       = {1'b0, i_state.logical_rank} ^ i_state.stage_mask;
    assign partner   = (dst < rem_ext) ? {dst[COUNT_W-2:0], 1'b1} : dst + rem_ext;
    assign mask_done = i_state.stage_mask >= i_state.pow2_floor;
    assign rank_up   = i_my_rank + RANK_W'(1);
    assign rank_dn   = i_my_rank - RANK_W'(1);

    // next state
    always_comb begin
        o_state = i_state;
        if (i_word.opcode == OP_START) begin
            o_state.phase           = i_start.phase;
            o_state.stage_mask      = COUNT_W'(1);
            o_state.stage_partner   = '0;
            o_state.logical_rank    = i_start.logical_rank;
            o_state.pow2_floor      = i_start.pow2_floor;
            o_state.remainder_count = i_start.remainder_count;
        end else begin
            case (i_state.phase)
                PH_START_PRE: begin
                    if (even ? i_word.local_write_done
                             : (i_word.local_write_done && i_word.incoming_write_done)) begin
                        o_state.phase = PH_DONE_PRE;
                    end
                end
                PH_DONE_PRE: begin
                    if (even && i_word.send_complete) begin
                        o_state.phase = PH_START_POST;
                    end else if (!even && i_word.recv_complete) begin
                        o_state.phase = PH_START_BF;
                    end
                end
                PH_START_BF: begin
                    if (mask_done) begin
                        o_state.phase = in_pre ? PH_START_POST : PH_RESULT;
                    end else begin
                        o_state.stage_partner = partner[RANK_W-1:0];
                        if (i_word.local_write_done && i_word.incoming_write_done) begin
                            o_state.phase = PH_DONE_BF;
                        end
                    end
                end
                PH_DONE_BF: begin
                    if (i_word.recv_complete && i_word.send_complete) begin
                        o_state.stage_mask = i_state.stage_mask << 1;
                        o_state.phase      = PH_START_BF;
                    end
                end
                PH_START_POST: begin
                    if (i_word.local_write_done) begin
                        o_state.phase = PH_DONE_POST;
                    end
                end
                PH_DONE_POST: begin
                    if (even ? i_word.recv_complete : i_word.send_complete) begin
                        o_state.phase = PH_RESULT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // command word
    always_comb begin
        o_word = '0;
        if (i_word.opcode == OP_POLL) begin
            case (i_state.phase)
                PH_START_PRE: begin
                    if (even && i_word.local_write_done) begin
                        o_word.issue_send = 1'b1;
                        o_word.peer_rank  = rank_up;
                    end else if (!even && i_word.local_write_done
                                 && i_word.incoming_write_done) begin
                        o_word.issue_recv = 1'b1;
                        o_word.peer_rank  = rank_dn;
                    end
                end
                PH_DONE_PRE: begin
                    if (!even && i_word.recv_complete) begin
                        o_word.do_reduce = 1'b1;
                    end
                end
                PH_START_BF: begin
                    if (!mask_done && i_word.local_write_done
                        && i_word.incoming_write_done) begin
                        o_word.issue_send = 1'b1;
                        o_word.issue_recv = 1'b1;
                        o_word.peer_rank  = partner[RANK_W-1:0];
                    end
                end
                PH_DONE_BF: begin
                    if (i_word.recv_complete && i_word.send_complete) begin
                        o_word.do_reduce    = 1'b1;
                        o_word.reduce_order = !(i_state.stage_partner < i_my_rank);
                    end
                end
                PH_START_POST: begin
                    if (i_word.local_write_done) begin
                        if (even) begin
                            o_word.issue_recv  = 1'b1;
                            o_word.recv_target = 1'b1;
                            o_word.peer_rank   = rank_up;
                        end else begin
                            o_word.issue_send = 1'b1;
                            o_word.peer_rank  = rank_dn;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        o_word.finished  = (o_state.phase == PH_RESULT);
        o_word.phase_now = o_state.phase;
    end

endmodule

// File: rtl/core/allreduce_schedule_sequencer_unit.sv
// Top level of the allreduce schedule sequencer: config registers, state, output register.
// Depends on ardss_pkg, ardss_start and ardss_step.
`timescale 1ns / 1ps
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_in_data          | word in
//  out     | o_out_valid, i_out_stall, o_out_data       | word out
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index/data | write in
//
//  One word per clock unless stalled; the result is registered for the next cycle.
//  The whole step is combinational logic from the state registers to the output register.
//  Input stalls only while a held result is itself stalled.
//  Reset: phase idle, stage mask 1, power-of-two floor 1, my_rank 0, num_ranks 1.
//  The config port is always ready.

module allreduce_schedule_sequencer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ardss_pkg::t_in_word             i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ardss_pkg::t_out_word            o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ardss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ardss_pkg::COUNT_W-1:0]   i_cfg_data
);
    import ardss_pkg::*;

    logic [RANK_W-1:0]  r_my_rank;
    logic [COUNT_W-1:0] r_num_ranks;
    t_seq_state         r_state;
    t_seq_state         n_state;
    logic               r_out_valid;
    t_out_word          r_out_data;
    t_out_word          n_out_data;
    t_start_info        start_info;
    logic               in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    ardss_start u_start (
        .i_my_rank   (r_my_rank),
        .i_num_ranks (r_num_ranks),
        .o_info      (start_info)
    );

    ardss_step u_step (
        .i_word    (i_in_data),
        .i_state   (r_state),
        .i_start   (start_info),
        .i_my_rank (r_my_rank),
        .o_state   (n_state),
        .o_word    (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_rank   <= '0;
            r_num_ranks <= COUNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_MY_RANK) begin
                r_my_rank <= i_cfg_data[RANK_W-1:0];
            end else if (i_cfg_index == CFG_NUM_RANKS) begin
                r_num_ranks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_IDLE;
            r_state.stage_mask      <= COUNT_W'(1);
            r_state.logical_rank    <= '0;
            r_state.stage_partner   <= '0;
            r_state.pow2_floor      <= COUNT_W'(1);
            r_state.remainder_count <= '0;
            r_out_valid             <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state.stage_mask) && $onehot(r_state.pow2_floor))
        else $error("stage mask or pow2 floor not one-hot");

    a_mask_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stage_mask <= r_state.pow2_floor)
        else $error("stage mask passed pow2 floor");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_state.remainder_count} < r_state.pow2_floor)
        else $error("remainder not below pow2 floor");

    a_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.finished == (o_out_data.phase_now == PH_RESULT)))
        else $error("finished flag disagrees with phase");

    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.opcode == OP_START) |=>
        (!o_out_data.issue_send && !o_out_data.issue_recv && !o_out_data.do_reduce))
        else $error("start word issued a command");

endmodule
